// ----- sv/shape_point_hit_test_core_assert.svh -----
// Assertion macros for the shape point hit test core.
`ifndef SHAPE_POINT_HIT_TEST_CORE_ASSERT_SVH
`define SHAPE_POINT_HIT_TEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define SPHT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spht: assertion failed");
// checked at every edge, reset included
`define SPHT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("spht: check failed");
`else
`define SPHT_ASSERT(name, prop)
`define SPHT_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ----- sv/spht_pkg.sv -----
// Shared types, widths and constants of the shape point hit test core.
package spht_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int MAX_POINTS_DEF = 256;

  localparam int CW      = 24;   // coordinate field width
  localparam int AW2     = 25;   // doubled stored point
  localparam int QW      = 30;   // doubled local query coordinate
  localparam int DW      = 31;   // differences of doubled coordinates
  localparam int OPW     = 33;   // signed multiplier operand
  localparam int PW      = 64;   // product width
  localparam int ACC_W   = 124;  // accumulator
  localparam int CHUNK   = 29;   // split point of wide operands
  localparam int LEN_W   = 52;
  localparam int T2SQ_W  = 41;
  localparam int CMAG_W  = 58;
  localparam int T_W     = 22;
  localparam int T2_W    = 20;
  localparam int ROT_SHIFT  = 13;
  localparam int ROUND_HALF = 1 << (ROT_SHIFT - 1);

  function automatic int isqrt_small(input int v);
    int r;
    r = 0;
    for (int i = 0; i < 64; i++) begin
      if (i * i <= v) r = i;
    end
    return r;
  endfunction

  localparam int EPS_SQ    = (1 << (2 * FRAC_BITS)) / 10000;
  localparam int LEN_EPS   = 4 * EPS_SQ;
  localparam int SHORT_MAX = isqrt_small(EPS_SQ);
  localparam int SIX2      = 12 << FRAC_BITS;

  typedef enum logic [1:0] {
    SHAPE_BOX   = 2'd0,
    SHAPE_SEG   = 2'd1,
    SHAPE_BRUSH = 2'd2
  } shape_e;

  typedef enum logic [1:0] {
    ITEM_CLEAR  = 2'd0,
    ITEM_APPEND = 2'd1,
    ITEM_QUERY  = 2'd2
  } item_e;

  typedef enum logic [2:0] {
    REG_SHAPE_KIND   = 3'd0,
    REG_CENTER_X     = 3'd1,
    REG_CENTER_Y     = 3'd2,
    REG_ROT_COS      = 3'd3,
    REG_ROT_SIN      = 3'd4,
    REG_SIZE_W       = 3'd5,
    REG_SIZE_H       = 3'd6,
    REG_STROKE_WIDTH = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_MID  = 2'd1,
    SH_TOP  = 2'd2
  } shift_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ROTX, S_ROTY, S_BOX, S_SEG,
    S_BR_T2, S_BR_LDA, S_BR_LDB, S_BR_LEN, S_BR_DOT,
    S_BR_CR, S_BR_CSQ, S_BR_DA, S_BR_DB, S_DONE
  } state_e;

  typedef struct packed {
    logic                  vld;
    logic                  clr;
    logic                  sub;
    shift_e                sh;
    logic signed [OPW-1:0] a;
    logic signed [OPW-1:0] b;
  } mac_op_t;

endpackage

// ----- sv/spht_ram.sv -----
// Generic single write, single read RAM with registered read data.
module spht_ram #(
  parameter int Width = 48,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/shape_point_hit_test_core.sv -----
// Shape point hit test core: config registers, point store and hit test sequencer.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, kind_i, point_*  | to core
//  out     | out_valid_o, out_stall_i, hit_o, status_o| from core
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i         | to core
//
// One item at a time. A brush query is bounded by the shared 32x32 multiply-accumulate
// unit and the point RAM read port, and it walks the stored points segment by segment.
// Reset clears the control state and point count; the point RAM is not cleared.
// The output register frees the input side: a new item is taken while a result
// still waits on out_stall_i; it parks in S_DONE only if that result is not gone.

`include "shape_point_hit_test_core_assert.svh"

module shape_point_hit_test_core #(
  parameter int MAX_POINTS = spht_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [23:0]                     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      kind_i,
  input  logic signed [spht_pkg::CW-1:0]  point_x_i,
  input  logic signed [spht_pkg::CW-1:0]  point_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic                            status_o
);

  localparam int CntW   = $clog2(MAX_POINTS + 1);
  localparam int IdxW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PointW = 2 * spht_pkg::CW;
  localparam int CW     = spht_pkg::CW;
  localparam int AW2    = spht_pkg::AW2;
  localparam int QW     = spht_pkg::QW;
  localparam int DW     = spht_pkg::DW;
  localparam int OPW    = spht_pkg::OPW;
  localparam int PW     = spht_pkg::PW;
  localparam int ACC_W  = spht_pkg::ACC_W;
  localparam int CHUNK  = spht_pkg::CHUNK;
  localparam int LEN_W  = spht_pkg::LEN_W;
  localparam int T2SQ_W = spht_pkg::T2SQ_W;
  localparam int CMAG_W = spht_pkg::CMAG_W;
  localparam int T_W    = spht_pkg::T_W;
  localparam int T2_W   = spht_pkg::T2_W;

  // ---------------- configuration registers ----------------
  logic [1:0]           shape_q;
  logic signed [23:0]   cx_q, cy_q, sw_q, sh_q;
  logic signed [15:0]   cos_q, sin_q;
  logic [19:0]          stroke_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= spht_pkg::SHAPE_BOX;
      cx_q     <= '0;
      cy_q     <= '0;
      cos_q    <= 16'sd16384;
      sin_q    <= '0;
      sw_q     <= '0;
      sh_q     <= '0;
      stroke_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spht_pkg::REG_SHAPE_KIND:   shape_q  <= cfg_wdata_i[1:0];
        spht_pkg::REG_CENTER_X:     cx_q     <= cfg_wdata_i;
        spht_pkg::REG_CENTER_Y:     cy_q     <= cfg_wdata_i;
        spht_pkg::REG_ROT_COS:      cos_q    <= cfg_wdata_i[15:0];
        spht_pkg::REG_ROT_SIN:      sin_q    <= cfg_wdata_i[15:0];
        spht_pkg::REG_SIZE_W:       sw_q     <= cfg_wdata_i;
        spht_pkg::REG_SIZE_H:       sh_q     <= cfg_wdata_i;
        spht_pkg::REG_STROKE_WIDTH: stroke_q <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer and datapath registers ----------------
  spht_pkg::state_e state_q, state_d;
  logic [3:0]          step_q, step_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     count_q, count_d;

  logic signed [AW2-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic signed [QW-1:0]    qx_q, qx_d, qy_q, qy_d;
  logic signed [AW2-1:0]   ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [T2SQ_W-1:0]       t2sq_q, t2sq_d;
  logic [CMAG_W-1:0]       cmag_q, cmag_d;
  logic                    res_hit_q, res_hit_d, res_status_q, res_status_d;
  logic                    out_vld_q, out_vld_d, out_hit_q, out_hit_d;
  logic                    out_status_q, out_status_d;

  // multiply-accumulate pipeline: product register, then accumulator
  spht_pkg::mac_op_t       op;
  logic [PW-1:0]           prod_q;
  logic                    prod_vld_q, prod_neg_q, prod_clr_q;
  spht_pkg::shift_e        prod_sh_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  // point store
  logic                    ram_we;
  logic [PointW-1:0]       ram_rdata;

  spht_ram #(
    .Width (PointW),
    .Depth (MAX_POINTS)
  ) u_points (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({point_x_i, point_y_i}),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  logic signed [AW2-1:0] rd_x2, rd_y2;
  assign rd_x2 = {ram_rdata[PointW-1 -: CW], 1'b0};
  assign rd_y2 = {ram_rdata[CW-1:0], 1'b0};

  // ---------------- combinational geometry ----------------
  logic signed [DW-1:0]    aqx, aqy, bqx, bqy, abx, aby;
  assign aqx = DW'(qx_q) - DW'(ax_q);
  assign aqy = DW'(qy_q) - DW'(ay_q);
  assign bqx = DW'(qx_q) - DW'(bx_q);
  assign bqy = DW'(qy_q) - DW'(by_q);
  assign abx = DW'(bx_q) - DW'(ax_q);
  assign aby = DW'(by_q) - DW'(ay_q);

  // segment: threshold, end-cap distance, short segment fallback
  logic [T_W-1:0]          t4, t_seg;
  logic [T2_W-1:0]         t2;
  logic [AW2-1:0]          abs_w;
  logic [QW-1:0]           abs_qx;
  logic signed [DW-1:0]    e_seg;
  assign t4     = {stroke_q, 2'b00};
  assign t_seg  = (t4 > T_W'(spht_pkg::SIX2)) ? t4 : T_W'(spht_pkg::SIX2);
  assign t2     = (stroke_q > T2_W'(spht_pkg::SIX2)) ? stroke_q : T2_W'(spht_pkg::SIX2);
  assign abs_w  = sw_q[23] ? AW2'(-AW2'(sw_q)) : AW2'(sw_q);
  assign abs_qx = qx_q[QW-1] ? QW'(-qx_q) : QW'(qx_q);

  always_comb begin
    if (abs_w <= AW2'(spht_pkg::SHORT_MAX)) begin
      e_seg = DW'(qx_q) + DW'(sw_q);
    end else if (DW'(abs_qx) <= DW'(abs_w)) begin
      e_seg = '0;
    end else begin
      e_seg = DW'(abs_qx) - DW'(abs_w);
    end
  end

  // box, inclusive bounds; a negative size never hits
  logic box_hit;
  assign box_hit = (DW'(qx_q) >= -DW'(sw_q)) && (DW'(qx_q) <= DW'(sw_q)) &&
                   (DW'(qy_q) >= -DW'(sh_q)) && (DW'(qy_q) <= DW'(sh_q));

  // accumulator readouts
  logic signed [ACC_W-1:0] acc_rnd;
  logic                    acc_le0;
  logic [ACC_W-1:0]        acc_abs;
  assign acc_rnd = acc_q + ACC_W'(spht_pkg::ROUND_HALF);
  assign acc_le0 = acc_q[ACC_W-1] || (acc_q == '0);
  assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  logic last_seg;
  assign last_seg = (CntW'(idx_q) + CntW'(1)) == count_q;

  // operand chunks for the wide cross-product compare
  logic [CHUNK-1:0] c_hi, c_lo, l_lo, t_lo;
  logic [LEN_W-CHUNK-1:0]  l_hi;
  logic [T2SQ_W-CHUNK-1:0] t_hi;
  assign c_hi = cmag_q[CMAG_W-1:CHUNK];
  assign c_lo = cmag_q[CHUNK-1:0];
  assign l_hi = len_q[LEN_W-1:CHUNK];
  assign l_lo = len_q[CHUNK-1:0];
  assign t_hi = t2sq_q[T2SQ_W-1:CHUNK];
  assign t_lo = t2sq_q[CHUNK-1:0];

  logic eval_now;

  // ---------------- next state, operations, results ----------------
  always_comb begin
    state_d      = state_q;
    step_d       = step_q + 4'd1;
    idx_d        = idx_q;
    count_d      = count_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    qx_d         = qx_q;
    qy_d         = qy_q;
    ax_d         = ax_q;
    ay_d         = ay_q;
    bx_d         = bx_q;
    by_d         = by_q;
    len_d        = len_q;
    t2sq_d       = t2sq_q;
    cmag_d       = cmag_q;
    res_hit_d    = res_hit_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    eval_now     = 1'b0;
    op           = '0;
    op.sh        = spht_pkg::SH_NONE;

    out_vld_d    = out_vld_q && out_stall_i;
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;

    unique case (state_q)
      spht_pkg::S_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          res_hit_d    = 1'b0;
          res_status_d = 1'b0;
          state_d      = spht_pkg::S_DONE;
          unique case (kind_i)
            spht_pkg::ITEM_CLEAR: count_d = '0;
            spht_pkg::ITEM_APPEND: begin
              if (count_q < CntW'(MAX_POINTS)) begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                res_status_d = 1'b1;
              end
            end
            spht_pkg::ITEM_QUERY: begin
              dx_d    = AW2'(point_x_i) - AW2'(cx_q);
              dy_d    = AW2'(point_y_i) - AW2'(cy_q);
              state_d = spht_pkg::S_ROTX;
            end
            default: ;
          endcase
        end
      end

      // local x = dx*cos + dy*sin, rounded to half units
      spht_pkg::S_ROTX: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(dx_q); op.b = OPW'(cos_q); end
          4'd1: begin op.vld = 1'b1; op.a = OPW'(dy_q); op.b = OPW'(sin_q); end
          4'd3: begin
            eval_now = 1'b1;
            qx_d     = acc_rnd[spht_pkg::ROT_SHIFT +: QW];
            state_d  = spht_pkg::S_ROTY;
            step_d   = '0;
          end
          default: ;
        endcase
      end

      // local y = dy*cos - dx*sin
      spht_pkg::S_ROTY: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(dy_q); op.b = OPW'(cos_q); end
          4'd1: begin
            op.vld = 1'b1; op.sub = 1'b1; op.a = OPW'(dx_q); op.b = OPW'(sin_q);
          end
          4'd3: begin
            eval_now = 1'b1;
            qy_d     = acc_rnd[spht_pkg::ROT_SHIFT +: QW];
            step_d   = '0;
            if (shape_q == spht_pkg::SHAPE_SEG) begin
              state_d = spht_pkg::S_SEG;
            end else if (shape_q == spht_pkg::SHAPE_BRUSH) begin
              idx_d = '0;
              if (count_q == '0) begin
                res_hit_d = 1'b0;
                state_d   = spht_pkg::S_DONE;
              end else begin
                state_d = spht_pkg::S_BR_T2;
              end
            end else begin
              state_d = spht_pkg::S_BOX;
            end
          end
          default: ;
        endcase
      end

      spht_pkg::S_BOX: begin
        res_hit_d = box_hit;
        state_d   = spht_pkg::S_DONE;
      end

      // e^2 + qy^2 - t^2 <= 0
      spht_pkg::S_SEG: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(e_seg); op.b = OPW'(e_seg); end
          4'd1: begin op.vld = 1'b1; op.a = OPW'(qy_q); op.b = OPW'(qy_q); end
          4'd2: begin
            op.vld = 1'b1; op.sub = 1'b1;
            op.a = OPW'(t_seg); op.b = OPW'(t_seg);
          end
          4'd4: begin
            eval_now  = 1'b1;
            res_hit_d = acc_le0;
            state_d   = spht_pkg::S_DONE;
          end
          default: ;
        endcase
      end

      spht_pkg::S_BR_T2: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(t2); op.b = OPW'(t2); end
          4'd2: begin
            eval_now = 1'b1;
            t2sq_d   = acc_q[T2SQ_W-1:0];
            state_d  = spht_pkg::S_BR_LDA;
            step_d   = '0;
          end
          default: ;
        endcase
      end

      // RAM read data is registered and arrives in the cycle after the address
      spht_pkg::S_BR_LDA: begin
        if (step_q == 4'd1) begin
          ax_d   = rd_x2;
          ay_d   = rd_y2;
          step_d = '0;
          if (count_q == CntW'(1)) begin
            state_d = spht_pkg::S_BR_DA;
          end else begin
            idx_d   = IdxW'(1);
            state_d = spht_pkg::S_BR_LDB;
          end
        end
      end

      spht_pkg::S_BR_LDB: begin
        if (step_q == 4'd1) begin
          bx_d    = rd_x2;
          by_d    = rd_y2;
          step_d  = '0;
          state_d = spht_pkg::S_BR_LEN;
        end
      end

      spht_pkg::S_BR_LEN: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(abx); op.b = OPW'(abx); end
          4'd1: begin op.vld = 1'b1; op.a = OPW'(aby); op.b = OPW'(aby); end
          4'd3: begin
            eval_now = 1'b1;
            len_d    = acc_q[LEN_W-1:0];
            step_d   = '0;
            // degenerate segment: distance to its first point
            if (acc_q <= $signed(ACC_W'(spht_pkg::LEN_EPS))) state_d = spht_pkg::S_BR_DA;
            else                                              state_d = spht_pkg::S_BR_DOT;
          end
          default: ;
        endcase
      end

      // projection of aq on ab, clamped at both ends
      spht_pkg::S_BR_DOT: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(aqx); op.b = OPW'(abx); end
          4'd1: begin op.vld = 1'b1; op.a = OPW'(aqy); op.b = OPW'(aby); end
          4'd3: begin
            eval_now = 1'b1;
            step_d   = '0;
            priority if (acc_le0)                            state_d = spht_pkg::S_BR_DA;
            else if (acc_q >= $signed(ACC_W'(len_q)))        state_d = spht_pkg::S_BR_DB;
            else                                             state_d = spht_pkg::S_BR_CR;
          end
          default: ;
        endcase
      end

      spht_pkg::S_BR_CR: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(aqx); op.b = OPW'(aby); end
          4'd1: begin
            op.vld = 1'b1; op.sub = 1'b1; op.a = OPW'(aqy); op.b = OPW'(abx);
          end
          4'd3: begin
            eval_now = 1'b1;
            cmag_d   = acc_abs[CMAG_W-1:0];
            step_d   = '0;
            state_d  = spht_pkg::S_BR_CSQ;
          end
          default: ;
        endcase
      end

      // cross^2 - t2sq*len in 29-bit chunks
      spht_pkg::S_BR_CSQ: begin
        unique case (step_q)
          4'd0: begin
            op.vld = 1'b1; op.clr = 1'b1; op.sh = spht_pkg::SH_TOP;
            op.a = OPW'(c_hi); op.b = OPW'(c_hi);
          end
          4'd1, 4'd2: begin
            op.vld = 1'b1; op.sh = spht_pkg::SH_MID;
            op.a = OPW'(c_hi); op.b = OPW'(c_lo);
          end
          4'd3: begin op.vld = 1'b1; op.a = OPW'(c_lo); op.b = OPW'(c_lo); end
          4'd4: begin
            op.vld = 1'b1; op.sub = 1'b1; op.sh = spht_pkg::SH_TOP;
            op.a = OPW'(t_hi); op.b = OPW'(l_hi);
          end
          4'd5: begin
            op.vld = 1'b1; op.sub = 1'b1; op.sh = spht_pkg::SH_MID;
            op.a = OPW'(t_hi); op.b = OPW'(l_lo);
          end
          4'd6: begin
            op.vld = 1'b1; op.sub = 1'b1; op.sh = spht_pkg::SH_MID;
            op.a = OPW'(t_lo); op.b = OPW'(l_hi);
          end
          4'd7: begin
            op.vld = 1'b1; op.sub = 1'b1; op.a = OPW'(t_lo); op.b = OPW'(l_lo);
          end
          4'd9: eval_now = 1'b1;
          default: ;
        endcase
      end

      spht_pkg::S_BR_DA: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(aqx); op.b = OPW'(aqx); end
          4'd1: begin op.vld = 1'b1; op.a = OPW'(aqy); op.b = OPW'(aqy); end
          4'd2: begin op.vld = 1'b1; op.sub = 1'b1; op.a = OPW'(t2); op.b = OPW'(t2); end
          4'd4: eval_now = 1'b1;
          default: ;
        endcase
      end

      spht_pkg::S_BR_DB: begin
        unique case (step_q)
          4'd0: begin op.vld = 1'b1; op.clr = 1'b1; op.a = OPW'(bqx); op.b = OPW'(bqx); end
          4'd1: begin op.vld = 1'b1; op.a = OPW'(bqy); op.b = OPW'(bqy); end
          4'd2: begin op.vld = 1'b1; op.sub = 1'b1; op.a = OPW'(t2); op.b = OPW'(t2); end
          4'd4: eval_now = 1'b1;
          default: ;
        endcase
      end

      spht_pkg::S_DONE: begin
        step_d = '0;
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d    = 1'b1;
          out_hit_d    = res_hit_q;
          out_status_d = res_status_q;
          state_d      = spht_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = spht_pkg::S_IDLE;
        step_d  = '0;
      end
    endcase

    // end of one brush segment test: hit, last segment, or move on
    if (eval_now && (state_q == spht_pkg::S_BR_DA || state_q == spht_pkg::S_BR_DB ||
                     state_q == spht_pkg::S_BR_CSQ)) begin
      step_d = '0;
      if (acc_le0) begin
        res_hit_d = 1'b1;
        state_d   = spht_pkg::S_DONE;
      end else if (last_seg) begin
        res_hit_d = 1'b0;
        state_d   = spht_pkg::S_DONE;
      end else begin
        ax_d    = bx_q;
        ay_d    = by_q;
        idx_d   = idx_q + IdxW'(1);
        state_d = spht_pkg::S_BR_LDB;
      end
    end
  end

  // ---------------- multiply-accumulate unit ----------------
  logic [OPW-1:0]   mag_a_w, mag_b_w;
  logic [31:0]      mag_a, mag_b;
  logic [7:0]       sh_amt;
  logic [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] term;

  assign mag_a_w = op.a[OPW-1] ? OPW'(-op.a) : OPW'(op.a);
  assign mag_b_w = op.b[OPW-1] ? OPW'(-op.b) : OPW'(op.b);
  assign mag_a   = mag_a_w[31:0];
  assign mag_b   = mag_b_w[31:0];

  always_comb begin
    unique case (prod_sh_q)
      spht_pkg::SH_MID: sh_amt = 8'(CHUNK);
      spht_pkg::SH_TOP: sh_amt = 8'(2 * CHUNK);
      default:          sh_amt = '0;
    endcase
  end

  assign shifted = ACC_W'(prod_q) << sh_amt;
  assign term    = prod_neg_q ? -$signed(shifted) : $signed(shifted);
  assign acc_d   = prod_vld_q ? ((prod_clr_q ? '0 : acc_q) + term) : acc_q;

  always_ff @(posedge clk_i) begin
    prod_q     <= PW'(mag_a) * PW'(mag_b);
    prod_neg_q <= op.a[OPW-1] ^ op.b[OPW-1] ^ op.sub;
    prod_clr_q <= op.clr;
    prod_sh_q  <= op.sh;
    acc_q      <= acc_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    bx_q       <= bx_d;
    by_q       <= by_d;
    len_q      <= len_d;
    t2sq_q     <= t2sq_d;
    cmag_q     <= cmag_d;
    res_hit_q    <= res_hit_d;
    res_status_q <= res_status_d;
    out_hit_q    <= out_hit_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= spht_pkg::S_IDLE;
      step_q     <= '0;
      idx_q      <= '0;
      count_q    <= '0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      idx_q      <= idx_d;
      count_q    <= count_d;
      prod_vld_q <= op.vld;
      out_vld_q  <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != spht_pkg::S_IDLE);
  assign out_valid_o = out_vld_q;
  assign hit_o       = out_hit_q;
  assign status_o    = out_status_q;

  // ---------------- assertions ----------------
  `SPHT_ASSERT(a_drop_when_full,
    (state_q == spht_pkg::S_DONE && res_status_q) |-> (count_q == CntW'(MAX_POINTS)))
  `SPHT_ASSERT(a_write_has_room, ram_we |-> (count_q < CntW'(MAX_POINTS)))
  `SPHT_ASSERT(a_acc_drained, eval_now |-> !prod_vld_q)
  `SPHT_ASSERT(a_idx_in_store,
    (state_q == spht_pkg::S_BR_LDB || state_q == spht_pkg::S_BR_LEN ||
     state_q == spht_pkg::S_BR_DOT || state_q == spht_pkg::S_BR_CSQ) |->
    (CntW'(idx_q) < count_q))
  `SPHT_ASSERT(a_hit_xor_drop, !(out_vld_q && out_hit_q && out_status_q))

endmodule

// ----- bench/shape_point_hit_test_checker.sv -----
// Channel monitor, hit test predictor and result scoreboard for the hit test core.
module shape_point_hit_test_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [23:0] point_x_i,
  input  logic [23:0] point_y_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        hit_o,
  input  logic        status_o,
  output int          errors_o,
  output int          pending_o
);
  import spht_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    logic hit;
    logic status;
  } verdict_t;

  localparam int    STORE_DEPTH = MAX_POINTS_DEF;
  localparam wide_t TINY_SQ     = (128'sd1 <<< (2 * FRAC_BITS)) / 10000;
  localparam wide_t SIX_PX2     = 128'sd12 <<< FRAC_BITS;

  // shadow of the shape registers
  logic [1:0]         shp_kind;
  logic signed [23:0] ctr_x, ctr_y, siz_w, siz_h;
  logic signed [15:0] cosv, sinv;
  logic [19:0]        stroke;

  logic signed [23:0] brush_x [STORE_DEPTH];
  logic signed [23:0] brush_y [STORE_DEPTH];
  int                 brush_cnt;

  verdict_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic wide_t sq(wide_t v);
    return v * v;
  endfunction

  function automatic bit near_stroke(wide_t qx, wide_t qy, wide_t ax, wide_t ay,
                                     wide_t bx, wide_t by, wide_t lim_sq);
    wide_t abx, aby, aqx, aqy, len, dot, crs;
    abx = bx - ax;
    aby = by - ay;
    aqx = qx - ax;
    aqy = qy - ay;
    len = sq(abx) + sq(aby);
    if (len <= 4 * TINY_SQ) return sq(aqx) + sq(aqy) <= lim_sq;
    dot = aqx * abx + aqy * aby;
    if (dot <= 0) return sq(aqx) + sq(aqy) <= lim_sq;
    if (dot >= len) return sq(qx - bx) + sq(qy - by) <= lim_sq;
    crs = aqx * aby - aqy * abx;
    return sq(crs) <= lim_sq * len;
  endfunction

  function automatic bit predict_hit(logic signed [23:0] px, logic signed [23:0] py);
    wide_t dx, dy, qx, qy, lim, wabs, ax, d2;
    bit    found;
    dx = wide_t'(px) - wide_t'(ctr_x);
    dy = wide_t'(py) - wide_t'(ctr_y);
    // local frame at half-unit precision, halves rounded up
    qx = (dx * wide_t'(cosv) + dy * wide_t'(sinv) + 4096) >>> 13;
    qy = (dy * wide_t'(cosv) - dx * wide_t'(sinv) + 4096) >>> 13;
    if (shp_kind == SHAPE_BRUSH) begin
      lim = (wide_t'(stroke) > SIX_PX2) ? wide_t'(stroke) : SIX_PX2;
      if (brush_cnt == 0) return 1'b0;
      if (brush_cnt == 1)
        return sq(qx - 2 * wide_t'(brush_x[0])) + sq(qy - 2 * wide_t'(brush_y[0]))
               <= sq(lim);
      found = 1'b0;
      for (int i = 1; i < brush_cnt; i++) begin
        if (near_stroke(qx, qy, 2 * wide_t'(brush_x[i-1]), 2 * wide_t'(brush_y[i-1]),
                        2 * wide_t'(brush_x[i]), 2 * wide_t'(brush_y[i]), sq(lim)))
          found = 1'b1;
      end
      return found;
    end
    if (shp_kind == SHAPE_SEG) begin
      lim = 4 * wide_t'(stroke);
      if (lim < SIX_PX2) lim = SIX_PX2;
      wabs = (siz_w < 0) ? -wide_t'(siz_w) : wide_t'(siz_w);
      ax = (qx < 0) ? -qx : qx;
      if (sq(wide_t'(siz_w)) <= TINY_SQ) d2 = sq(qx + wide_t'(siz_w)) + sq(qy);
      else if (ax <= wabs) d2 = sq(qy);
      else d2 = sq(ax - wabs) + sq(qy);
      return d2 <= sq(lim);
    end
    // box, also for the unused shape code
    return qx >= -wide_t'(siz_w) && qx <= wide_t'(siz_w) &&
           qy >= -wide_t'(siz_h) && qy <= wide_t'(siz_h);
  endfunction

  task automatic report_mismatch(string field, logic want, logic got);
    $display("%0t: %s mismatch, expected %0b, got %0b", $realtime, field, want, got);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      shp_kind  <= SHAPE_BOX;
      ctr_x     <= '0;
      ctr_y     <= '0;
      cosv      <= 16'sd16384;
      sinv      <= '0;
      siz_w     <= '0;
      siz_h     <= '0;
      stroke    <= '0;
      brush_cnt = 0;
      errors_o  = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SHAPE_KIND:   shp_kind <= cfg_wdata_i[1:0];
          REG_CENTER_X:     ctr_x    <= cfg_wdata_i;
          REG_CENTER_Y:     ctr_y    <= cfg_wdata_i;
          REG_ROT_COS:      cosv     <= cfg_wdata_i[15:0];
          REG_ROT_SIN:      sinv     <= cfg_wdata_i[15:0];
          REG_SIZE_W:       siz_w    <= cfg_wdata_i;
          REG_SIZE_H:       siz_h    <= cfg_wdata_i;
          REG_STROKE_WIDTH: stroke   <= cfg_wdata_i[19:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        want = '0;
        case (kind_i)
          ITEM_CLEAR: brush_cnt = 0;
          ITEM_APPEND: begin
            if (brush_cnt < STORE_DEPTH) begin
              brush_x[brush_cnt] = point_x_i;
              brush_y[brush_cnt] = point_y_i;
              brush_cnt++;
            end else want.status = 1'b1;
          end
          ITEM_QUERY: want.hit = predict_hit(point_x_i, point_y_i);
          default: ;
        endcase
        expected_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result item with nothing expected", $realtime);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (hit_o !== want.hit) report_mismatch("hit", want.hit, hit_o);
          if (status_o !== want.status) report_mismatch("status", want.status, status_o);
        end
      end
    end
  end

endmodule

// ----- bench/tb_shape_point_hit_test_core.sv -----
// Testbench top: clock, reset, stimulus and verdict for the shape point hit test core.
module tb_shape_point_hit_test_core;
  import spht_pkg::*;

  localparam logic [1:0] ITEM_UNKNOWN  = 2'd3;
  localparam logic [1:0] SHAPE_UNKNOWN = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_SHAPE_KIND;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = ITEM_CLEAR;
  logic signed [23:0] point_x_i = '0;
  logic signed [23:0] point_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        hit_o, status_o;
  int          errors, pending;

  // idling control shared by both sides
  bit idle_on = 1'b1;
  bit hold_go = 1'b0;
  // center of the current shape, so queries land near it
  int cur_cx, cur_cy;

  always #1 clk_i = ~clk_i;

  shape_point_hit_test_core i_dut (.*);

  shape_point_hit_test_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .kind_i, .point_x_i, .point_y_i,
    .out_valid_o, .out_stall_i, .hit_o, .status_o,
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random stalls, plus one long hold-off counted here while the
  // sender keeps offering items, so the core backs up and stalls its input.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 18);
      end
    end
  end

  // one item; returns right after the accepting edge
  task automatic send_item(logic [1:0] k, logic [23:0] x, logic [23:0] y);
    while (idle_on && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    point_x_i  <= x;
    point_y_i  <= y;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain, then a register write while the core sits idle
  task automatic write_reg(cfg_reg_e idx, logic [23:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CENTER_X) cur_cx = signed'(data);
    if (idx == REG_CENTER_Y) cur_cy = signed'(data);
  endtask

  task automatic set_shape(logic [1:0] shp, int cx, int cy, int c, int s,
                           int w, int h, int sw);
    write_reg(REG_SHAPE_KIND, 24'(shp));
    write_reg(REG_CENTER_X, 24'(cx));
    write_reg(REG_CENTER_Y, 24'(cy));
    write_reg(REG_ROT_COS, 24'(c));
    write_reg(REG_ROT_SIN, 24'(s));
    write_reg(REG_SIZE_W, 24'(w));
    write_reg(REG_SIZE_H, 24'(h));
    write_reg(REG_STROKE_WIDTH, 24'(sw));
  endtask

  // query near the shape center, now and then anywhere
  task automatic near_query(int span);
    int ox, oy;
    if ($urandom_range(9) == 0) begin
      send_item(ITEM_QUERY, 24'($urandom), 24'($urandom));
    end else begin
      ox = $urandom_range(2 * span) - span;
      oy = $urandom_range(2 * span) - span;
      send_item(ITEM_QUERY, 24'(cur_cx + ox), 24'(cur_cy + oy));
    end
  endtask

  function automatic int pick_rot();
    case ($urandom_range(5))
      0: return 16384;
      1: return -16384;
      2: return 0;
      3: return 11585;
      4: return -11585;
      default: return $urandom_range(32768) - 16384;
    endcase
  endfunction

  function automatic int pick_len();
    case ($urandom_range(5))
      0: return $urandom_range(4) - 2;         // near zero length
      1: return -($urandom_range(4000));       // negative size
      default: return $urandom_range(8000);
    endcase
  endfunction

  // short polyline with random content, then queries around the shape center
  task automatic brush_round(int n_pts, int n_q);
    send_item(ITEM_CLEAR, 24'($urandom), 24'($urandom));
    for (int i = 0; i < n_pts; i++)
      send_item(ITEM_APPEND, 24'($urandom_range(8000) - 4000),
                24'($urandom_range(8000) - 4000));
    for (int i = 0; i < n_q; i++) near_query(6000);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset shape (box of zero size), each item kind, field extremes
    send_item(ITEM_QUERY, 24'd0, 24'd0);
    send_item(ITEM_QUERY, 24'h7FFFFF, 24'h800000);
    send_item(ITEM_QUERY, 24'h800000, 24'h7FFFFF);
    send_item(ITEM_QUERY, 24'd1, 24'd0);
    send_item(ITEM_UNKNOWN, 24'hFFFFFF, 24'hFFFFFF);
    send_item(ITEM_APPEND, 24'h7FFFFF, 24'h800000);
    send_item(ITEM_CLEAR, 24'd0, 24'd0);
    // brush with no points, one point, a zero-length stroke, then a stroke to the extremes
    set_shape(SHAPE_BRUSH, 0, 0, 16384, 0, 0, 0, 0);
    send_item(ITEM_QUERY, 24'd0, 24'd0);
    send_item(ITEM_APPEND, 24'd100, 24'd100);
    send_item(ITEM_QUERY, 24'd100, 24'd100);
    send_item(ITEM_QUERY, 24'd2000, 24'd100);
    send_item(ITEM_APPEND, 24'd100, 24'd100);   // zero-length stroke
    send_item(ITEM_QUERY, 24'd120, 24'd100);
    send_item(ITEM_APPEND, 24'h7FFFFF, 24'h800000);
    send_item(ITEM_QUERY, 24'h7FFFFF, 24'h800000);
    send_item(ITEM_QUERY, 24'd0, 24'd0);
    // extremes of every register, unnormalized rotation
    set_shape(SHAPE_SEG, 8388607, -8388608, -16384, 16384, -8388608, 8388607, 1048575);
    send_item(ITEM_QUERY, 24'h7FFFFF, 24'h800000);
    send_item(ITEM_QUERY, 24'h800000, 24'h7FFFFF);
    set_shape(SHAPE_UNKNOWN, -8388608, 8388607, 16384, -16384, 8388607, -8388608, 0);
    send_item(ITEM_QUERY, 24'h800000, 24'h7FFFFF);
    send_item(ITEM_QUERY, 24'h7FFFFF, 24'h7FFFFF);
    // short segment: distance to its start point
    set_shape(SHAPE_SEG, 0, 0, 16384, 0, 2, 0, 0);
    send_item(ITEM_QUERY, 24'd0, 24'd0);
    send_item(ITEM_QUERY, 24'd3100, 24'd0);

    // random phases, one shape setting each
    for (int ph = 0; ph < 14; ph++) begin
      idle_on = (ph != 5);   // one long stretch with no idling
      case (ph % 4)
        0: set_shape(SHAPE_BOX, $urandom_range(20000) - 10000,
                     $urandom_range(20000) - 10000, pick_rot(), pick_rot(),
                     pick_len(), pick_len(), $urandom_range(1048575));
        1: set_shape(SHAPE_SEG, $urandom_range(20000) - 10000,
                     $urandom_range(20000) - 10000, pick_rot(), pick_rot(),
                     pick_len(), pick_len(), $urandom_range(3) == 0 ?
                     $urandom_range(1048575) : $urandom_range(2000));
        2: set_shape(SHAPE_BRUSH, $urandom_range(20000) - 10000,
                     $urandom_range(20000) - 10000, pick_rot(), pick_rot(),
                     pick_len(), pick_len(), $urandom_range(3) == 0 ?
                     $urandom_range(1048575) : $urandom_range(6000));
        default: set_shape(SHAPE_UNKNOWN, $urandom(), $urandom(), pick_rot(),
                           pick_rot(), pick_len(), pick_len(), $urandom());
      endcase
      if (ph == 3) hold_go = 1'b1;
      if (ph % 4 == 2) begin
        for (int r = 0; r < 4; r++) brush_round($urandom_range(7), $urandom_range(6, 2));
      end else begin
        for (int i = 0; i < 15; i++) begin
          if ($urandom_range(9) == 0)
            send_item(2'($urandom), 24'($urandom), 24'($urandom));
          else
            near_query(20000);
        end
      end
    end

    // fill the store past its capacity, then a few full-length brush queries
    set_shape(SHAPE_BRUSH, 0, 0, 16384, 0, 0, 0, 3000);
    send_item(ITEM_CLEAR, 24'd0, 24'd0);
    for (int i = 0; i < MAX_POINTS_DEF + 4; i++)
      send_item(ITEM_APPEND, 24'(i * 40 - 5000), 24'($urandom_range(400) - 200));
    for (int i = 0; i < 3; i++) near_query(8000);
    send_item(ITEM_CLEAR, 24'd0, 24'd0);
    send_item(ITEM_QUERY, 24'd0, 24'd0);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/spht_pkg.sv
sv/spht_ram.sv
sv/shape_point_hit_test_core.sv
bench/shape_point_hit_test_checker.sv
bench/tb_shape_point_hit_test_core.sv
